// File: hw/rtl/wrapping_time_min_heap_core_macros.svh
// Assertion helpers for the timer heap core.
`ifndef WRAPPING_TIME_MIN_HEAP_CORE_MACROS_SVH
`define WRAPPING_TIME_MIN_HEAP_CORE_MACROS_SVH

// pre implies post in the same cycle
`define WTMH_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("wtmh same-cycle check failed");

// pre implies post in the next cycle
`define WTMH_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("wtmh next-cycle check failed");

`endif

// File: hw/rtl/wtmh_pkg.sv
package wtmh_pkg;

   localparam int CMD_W    = 2;
   localparam int TIME_W   = 16;
   localparam int TAG_W    = 16;
   localparam int REC_W    = TIME_W + TAG_W;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_READ,
      S_UP_CMP,
      S_DN_ROOT,
      S_DN_LAST,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_DN_PICK,
      S_DN_MOVE,
      S_PEEK,
      S_DONE
   } state_type;

   // a comes no later than b: signed upper half of (a - b) is <= 0
   function automatic logic order_le(input logic [REC_W-1:0] a, input logic [REC_W-1:0] b);
      logic [REC_W-1:0] d;
      d = a - b;
      return d[REC_W-1] || (d[REC_W-1:TAG_W] == '0);
   endfunction

   // signed upper half of (a - b) is >= 0
   function automatic logic order_ge(input logic [REC_W-1:0] a, input logic [REC_W-1:0] b);
      logic [REC_W-1:0] d;
      d = a - b;
      return !d[REC_W-1];
   endfunction

endpackage

// File: hw/rtl/wrapping_time_min_heap_core.sv
// Timer queue: binary min-heap of {due time, tag} entries ordered by wrapping
// 16-bit time. One command beat on req_* (insert, pop, peek) gives exactly one
// result beat on rsp_*.
// Handshake: a beat moves when valid is high and stall is low. req_stall is
// high while a command is being worked on; a new command is taken as soon as
// the previous result has been handed to the output register, even if the
// receiver is still stalling that result.
// Steps per command: insert sifts the new entry up from the new last slot;
// pop reads the root, then the last entry, and sifts that entry down from
// the root; peek reads the root; rejected, empty-heap and unused commands
// go straight to the done state.
// The heap lives in one single-port-read, single-port-write RAM with a
// registered read; each level of sift-up costs a read and a write-back, each
// level of sift-down one or two child reads, a pick and a write-back. A new
// command is taken only after the previous result has loaded.
// Reset (synchronous, active high) empties the heap by clearing the entry
// count; the RAM is not cleared, only entries below the count are ever read.
// While rsp_stall is high the result holds on rsp_*; a finished command waits
// in its done state until the output register frees up.
module wrapping_time_min_heap_core #(
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [wtmh_pkg::CMD_W-1:0]     req_cmd,
   input  logic [wtmh_pkg::TIME_W-1:0]    req_time_req,
   input  logic [wtmh_pkg::TAG_W-1:0]     req_tag,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [wtmh_pkg::STATUS_W-1:0]  rsp_status,
   output logic [wtmh_pkg::TIME_W-1:0]    rsp_entry_time,
   output logic [wtmh_pkg::TAG_W-1:0]     rsp_entry_tag,
   output logic                           rsp_entry_valid,
   output logic                           rsp_due,
   output logic [wtmh_pkg::COUNT_W-1:0]   rsp_count
);

   import wtmh_pkg::*;

`include "wrapping_time_min_heap_core_macros.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = AW + 2;

   // control state
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [AW-1:0]    idx_ff, idx_in;
   logic [AW-1:0]    pick_idx_ff, pick_idx_in;
   logic [REC_W-1:0] rec_ff, rec_in;
   logic [REC_W-1:0] left_ff, left_in;
   logic [REC_W-1:0] pick_ff, pick_in;
   logic             has_r_ff, has_r_in;

   // staged result
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [TIME_W-1:0]   res_time_ff, res_time_in;
   logic [TAG_W-1:0]    res_tag_ff, res_tag_in;
   logic                res_valid_ff, res_valid_in;
   logic                res_due_ff, res_due_in;

   // output register
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [TIME_W-1:0]   rsp_time_ff;
   logic [TAG_W-1:0]    rsp_tag_ff;
   logic                rsp_evalid_ff;
   logic                rsp_due_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                load_rsp;

   // RAM port
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [REC_W-1:0] mem_wdata;
   logic             mem_re;
   logic [AW-1:0]    mem_raddr;
   logic [REC_W-1:0] mem_rd;

   // heap index arithmetic
   logic [XW-1:0] child_l, child_r, n_x;
   logic [AW-1:0] parent_idx;
   logic          full, empty;
   logic          pop_accept;

   assign child_l    = XW'({idx_ff, 1'b1});
   assign child_r    = child_l + XW'(1);
   assign n_x        = XW'(count_ff);
   assign parent_idx = (idx_ff - AW'(1)) >> 1;
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign pop_accept = req_valid && !req_stall && (req_cmd == CMD_POP) && !empty;

   assign req_stall = (state_ff != S_IDLE);

   wtmh_ram #(
      .DEPTH(DEPTH),
      .WIDTH(REC_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rd)
   );

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pick_idx_ff   <= pick_idx_in;
      rec_ff        <= rec_in;
      left_ff       <= left_in;
      pick_ff       <= pick_in;
      has_r_ff      <= has_r_in;
      res_status_ff <= res_status_in;
      res_time_ff   <= res_time_in;
      res_tag_ff    <= res_tag_in;
      res_valid_ff  <= res_valid_in;
      res_due_ff    <= res_due_in;
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_time_ff   <= res_time_ff;
         rsp_tag_ff    <= res_tag_ff;
         rsp_evalid_ff <= res_valid_ff;
         rsp_due_ff    <= res_due_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   // sequencer: one RAM access per port per cycle; a write and a read in the
   // same cycle never touch the same entry, so no forwarding is needed
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pick_idx_in   = pick_idx_ff;
      rec_in        = rec_ff;
      left_in       = left_ff;
      pick_in       = pick_ff;
      has_r_in      = has_r_ff;
      res_status_in = res_status_ff;
      res_time_in   = res_time_ff;
      res_tag_in    = res_tag_ff;
      res_valid_in  = res_valid_ff;
      res_due_in    = res_due_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      load_rsp      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rec_in        = {req_time_req, req_tag};
               res_status_in = STAT_OK;
               res_time_in   = '0;
               res_tag_in    = '0;
               res_valid_in  = 1'b0;
               res_due_in    = 1'b0;
               state_in      = S_DONE;
               case (req_cmd)
                  CMD_INSERT: begin
                     if (full) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        idx_in   = count_ff[AW-1:0];
                        count_in = count_ff + CW'(1);
                        state_in = S_UP_READ;
                     end
                  end
                  CMD_POP: begin
                     if (empty) begin
                        res_status_in = STAT_EMPTY;
                     end else begin
                        mem_re   = 1'b1;
                        count_in = count_ff - CW'(1);
                        state_in = S_DN_ROOT;
                     end
                  end
                  CMD_PEEK: begin
                     if (empty) begin
                        res_status_in = STAT_EMPTY;
                     end else begin
                        mem_re   = 1'b1;
                        state_in = S_PEEK;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // sift-up: place the entry at the root, else fetch parent of the hole
         S_UP_READ: begin
            if (idx_ff == '0) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               mem_wdata = rec_ff;
               state_in  = S_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = parent_idx;
               state_in  = S_UP_CMP;
            end
         end

         // parent no later than new entry: settle, else move parent down
         S_UP_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            if (order_le(mem_rd, rec_ff)) begin
               mem_wdata = rec_ff;
               state_in  = S_DONE;
            end else begin
               mem_wdata = mem_rd;
               idx_in    = parent_idx;
               state_in  = S_UP_READ;
            end
         end

         // root arrives; fetch last entry
         S_DN_ROOT: begin
            res_time_in  = mem_rd[REC_W-1:TAG_W];
            res_tag_in   = mem_rd[TAG_W-1:0];
            res_valid_in = 1'b1;
            mem_re       = 1'b1;
            mem_raddr    = count_ff[AW-1:0];
            state_in     = S_DN_LAST;
         end

         S_DN_LAST: begin
            rec_in   = mem_rd;
            idx_in   = '0;
            state_in = S_DN_LEFT;
         end

         // sift-down: fetch left child or settle at a leaf
         S_DN_LEFT: begin
            if (child_l >= n_x) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               mem_wdata = rec_ff;
               state_in  = S_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = child_l[AW-1:0];
               state_in  = S_DN_RIGHT;
            end
         end

         S_DN_RIGHT: begin
            left_in  = mem_rd;
            has_r_in = (child_r < n_x);
            if (child_r < n_x) begin
               mem_re    = 1'b1;
               mem_raddr = child_r[AW-1:0];
            end
            state_in = S_DN_PICK;
         end

         // right child wins unless left is earlier; on equal times the lower tag wins, right on equal tags
         S_DN_PICK: begin
            if (has_r_ff && order_ge(left_ff, mem_rd)) begin
               pick_in     = mem_rd;
               pick_idx_in = child_r[AW-1:0];
            end else begin
               pick_in     = left_ff;
               pick_idx_in = child_l[AW-1:0];
            end
            state_in = S_DN_MOVE;
         end

         S_DN_MOVE: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            if (order_le(rec_ff, pick_ff)) begin
               mem_wdata = rec_ff;
               state_in  = S_DONE;
            end else begin
               mem_wdata = pick_ff;
               idx_in    = pick_idx_ff;
               state_in  = S_DN_LEFT;
            end
         end

         S_PEEK: begin
            res_time_in  = mem_rd[REC_W-1:TAG_W];
            res_tag_in   = mem_rd[TAG_W-1:0];
            res_valid_in = 1'b1;
            res_due_in   = order_le(mem_rd, {rec_ff[REC_W-1:TAG_W], TAG_W'(0)});
            state_in     = S_DONE;
         end

         // hand result to the output register once it frees up
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_time  = rsp_time_ff;
   assign rsp_entry_tag   = rsp_tag_ff;
   assign rsp_entry_valid = rsp_evalid_ff;
   assign rsp_due         = rsp_due_ff;
   assign rsp_count       = rsp_count_ff;

   // checks
   `WTMH_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `WTMH_ASSERT_NEXT(a_pop_count, clock, reset, pop_accept, count_ff == $past(count_ff) - CW'(1))
   `WTMH_ASSERT_NOW(a_no_write_idle, clock, reset, mem_we, state_ff != S_IDLE)
   `WTMH_ASSERT_NOW(a_empty_no_entry, clock, reset, rsp_valid && rsp_status == STAT_EMPTY, !rsp_entry_valid && !rsp_due)

endmodule

// File: hw/rtl/wtmh_ram.sv
module wtmh_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, data valid in the cycle after rd_en
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
